>>> sv/tss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types and fixed field widths of the tick stream statistics block.
// ----------------------------------------------------------------------------
package tss_pkg;

	localparam int SEQ_BITS   = 64;
	localparam int TIME_BITS  = 64;
	localparam int QTY_BITS   = 40;
	localparam int QTY_HALF   = 20;
	localparam int LAT_BITS   = 63;
	localparam int RET_BITS   = 48;
	localparam int FRAC_BITS  = 32;
	localparam int INST_BITS  = 10;
	localparam int COUNT_BITS = 11;
	localparam int SUM_BITS   = 64;
	localparam int MUL_STEPS  = 4;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [LAT_BITS-1:0]   LAT_MAX   = '1;
	localparam logic [SUM_BITS-1:0]   RET_MAX   = {{(SUM_BITS-RET_BITS){1'b0}}, {RET_BITS{1'b1}}};

	typedef enum logic {
		F_IDLE,
		F_LOOK
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_RUN,
		B_ACC
	} back_state_t;

	typedef struct packed {
		logic clearing;
		logic push;
	} front_stat_t;

endpackage

>>> sv/tss_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_fifo
// Two-entry queue that decouples the classify front from the arithmetic back.
// ----------------------------------------------------------------------------
module tss_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         not_empty
);

	logic [W-1:0] mem_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	assign full      = cnt_q == 2'd2;
	assign not_empty = cnt_q != 2'd0;
	assign pop_data  = mem_q[rd_ptr_q];

endmodule

>>> sv/tss_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_front
// Accepts ticks, looks up the last price of the instrument and classifies.
// ----------------------------------------------------------------------------
module tss_front import tss_pkg::*; #(
	parameter int SLOTS = 1024,
	parameter int PB    = 48
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_valid,
	output logic                   s_ready,
	input  logic [SEQ_BITS-1:0]    seq,
	input  logic [TIME_BITS-1:0]   ev,
	input  logic [TIME_BITS-1:0]   rx,
	input  logic [PB-1:0]          price,
	input  logic [QTY_BITS-1:0]    qty,
	input  logic [PB-1:0]          bid,
	input  logic [PB-1:0]          ask,
	input  logic [INST_BITS-1:0]   inst,
	input  logic                   full,
	output logic [SEQ_BITS-1:0]    r_seq,
	output logic [LAT_BITS-1:0]    r_lat,
	output logic [QTY_BITS-1:0]    r_qty,
	output logic [PB-1:0]          r_price,
	output logic [PB-1:0]          r_mid,
	output logic [PB:0]            r_spread,
	output logic                   r_new_slot,
	output logic                   r_has_ret,
	output logic [PB-1:0]          r_diff,
	output logic [PB-1:0]          r_last,
	output front_stat_t            stat
);

	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int IW = (AW > INST_BITS) ? AW : INST_BITS;

	front_state_t state_q, state_d;
	logic [PB:0]  mem [SLOTS];
	logic [PB:0]  rd_q;
	logic [AW:0]  clr_idx_q;
	logic         clearing_q;

	logic [SEQ_BITS-1:0]  seq_q;
	logic [TIME_BITS-1:0] ev_q, rx_q;
	logic [PB-1:0]        price_q, bid_q, ask_q;
	logic [QTY_BITS-1:0]  qty_q;
	logic [AW-1:0]        addr_q;
	logic                 inr_q;

	logic [IW-1:0]        inst_ext;
	logic                 accept, push;
	logic [TIME_BITS:0]   diff;
	logic                 lat_pos;
	logic [PB:0]          pair_sum;
	logic [PB-1:0]        last;

	assign inst_ext = IW'(inst);
	assign accept   = s_valid && s_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= F_IDLE;
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else begin
			state_q <= state_d;
			if (clearing_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == (AW+1)'(SLOTS - 1)) clearing_q <= 1'b0;
			end
		end
	end

	// Slot store: valid flag on top of the price; the clearing pass owns the
	// write port until every entry is zero.
	always_ff @(posedge clk) begin
		if (clearing_q) mem[clr_idx_q[AW-1:0]] <= '0;
		else if (push && inr_q) mem[addr_q] <= {1'b1, price_q};
		if (accept) rd_q <= mem[inst_ext[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			seq_q   <= seq;
			ev_q    <= ev;
			rx_q    <= rx;
			price_q <= price;
			qty_q   <= qty;
			bid_q   <= bid;
			ask_q   <= ask;
			addr_q  <= inst_ext[AW-1:0];
			inr_q   <= 32'(inst) < SLOTS;
		end
	end

	always_comb begin
		state_d = state_q;
		s_ready = 1'b0;
		push    = 1'b0;
		case (state_q)
			F_IDLE: begin
				s_ready = !clearing_q;
				if (accept) state_d = F_LOOK;
			end
			F_LOOK: begin
				push = !full;
				if (!full) state_d = F_IDLE;
			end
			default: state_d = F_IDLE;
		endcase
	end

	assign diff     = {rx_q[TIME_BITS-1], rx_q} - {ev_q[TIME_BITS-1], ev_q};
	assign lat_pos  = !diff[TIME_BITS] && (diff != '0);
	assign pair_sum = {1'b0, ask_q} + {1'b0, bid_q};
	assign last     = rd_q[PB-1:0];

	assign r_seq      = seq_q;
	assign r_lat      = !lat_pos ? '0 : (diff[TIME_BITS-1] ? LAT_MAX : diff[LAT_BITS-1:0]);
	assign r_qty      = qty_q;
	assign r_price    = price_q;
	assign r_mid      = pair_sum[PB:1];
	assign r_spread   = {1'b0, ask_q} - {1'b0, bid_q};
	assign r_new_slot = inr_q && !rd_q[PB];
	assign r_has_ret  = inr_q && rd_q[PB] && (last != '0);
	assign r_diff     = (price_q >= last) ? price_q - last : last - price_q;
	assign r_last     = last;

	assign stat.clearing = clearing_q;
	assign stat.push     = push;

endmodule

>>> sv/tss_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_back
// Multi-cycle notional product, bit-serial return divider and running totals.
// ----------------------------------------------------------------------------
module tss_back import tss_pkg::*; #(
	parameter int PB = 48
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rec_valid,
	output logic                  pop,
	input  logic [SEQ_BITS-1:0]   r_seq,
	input  logic [LAT_BITS-1:0]   r_lat,
	input  logic [QTY_BITS-1:0]   r_qty,
	input  logic [PB-1:0]         r_price,
	input  logic [PB-1:0]         r_mid,
	input  logic [PB:0]           r_spread,
	input  logic                  r_new_slot,
	input  logic                  r_has_ret,
	input  logic [PB-1:0]         r_diff,
	input  logic [PB-1:0]         r_last,
	output logic                  m_valid,
	input  logic                  m_ready,
	output logic [SUM_BITS-1:0]   ticks,
	output logic [SUM_BITS-1:0]   errors,
	output logic [COUNT_BITS-1:0] count,
	output logic [SUM_BITS-1:0]   qty_sum,
	output logic [SUM_BITS-1:0]   notional_sum,
	output logic [SUM_BITS-1:0]   spread_sum,
	output logic [SUM_BITS-1:0]   mid_sum,
	output logic [SUM_BITS-1:0]   ret_sum,
	output logic [LAT_BITS-1:0]   lat_max
);

	localparam int PL  = (PB + 1) / 2;
	localparam int PW  = PB + QTY_BITS;
	localparam int DW  = PB + FRAC_BITS;
	localparam int CW  = $clog2(DW + 1);

	back_state_t state_q, state_d;

	logic [SEQ_BITS-1:0] seq_q;
	logic [LAT_BITS-1:0] lat_q;
	logic [QTY_BITS-1:0] qty_q;
	logic [PB-1:0]       price_q, mid_q, last_q;
	logic [PB:0]         spread_q;
	logic                new_slot_q;

	logic [2:0]          mstep_q;
	logic [PL+QTY_HALF-1:0] prod_q;
	logic [6:0]          shift_q;
	logic [PW-1:0]       acc_q;

	logic [CW-1:0]       dcnt_q;
	logic [PB:0]         rem_q;
	logic [DW-1:0]       quo_q;

	logic [SEQ_BITS-1:0] next_q;
	logic                known_q;
	logic                m_valid_q;

	logic                update;
	logic [PL-1:0]       mul_a;
	logic [QTY_HALF-1:0] mul_b;
	logic [PB:0]         trial;
	logic                ge;
	logic                run_done;
	logic [SUM_BITS-1:0] notional_term, ret_term;
	logic [SUM_BITS:0]   qty_add, not_add, mid_add, ret_add;
	logic [SUM_BITS+1:0] sp_add;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= B_IDLE;
		else state_q <= state_d;
	end

	assign run_done = (mstep_q == 3'(MUL_STEPS + 1)) && (dcnt_q == CW'(DW));
	assign update   = (state_q == B_ACC) && (!m_valid_q || m_ready);

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		case (state_q)
			B_IDLE: begin
				pop = rec_valid;
				if (rec_valid) state_d = B_RUN;
			end
			B_RUN:   if (run_done) state_d = B_ACC;
			B_ACC:   if (update) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	// Partial products: price halves times quantity halves, one a cycle.
	assign mul_a = mstep_q[0] ? PL'(price_q[PB-1:PL]) : price_q[PL-1:0];
	assign mul_b = mstep_q[1] ? qty_q[QTY_BITS-1:QTY_HALF] : qty_q[QTY_HALF-1:0];

	// Restoring division of (diff << 32) by the last price, one bit a cycle.
	assign trial = {rem_q[PB-1:0], quo_q[DW-1]};
	assign ge    = trial >= {1'b0, last_q};

	always_ff @(posedge clk) begin
		if (pop) begin
			seq_q      <= r_seq;
			lat_q      <= r_lat;
			qty_q      <= r_qty;
			price_q    <= r_price;
			mid_q      <= r_mid;
			spread_q   <= r_spread;
			new_slot_q <= r_new_slot;
			last_q     <= r_last;
			mstep_q    <= '0;
			acc_q      <= '0;
			rem_q      <= '0;
			// Without a return term the quotient stays zero and adds nothing.
			quo_q      <= r_has_ret ? {r_diff, {FRAC_BITS{1'b0}}} : '0;
			dcnt_q     <= r_has_ret ? '0 : CW'(DW);
		end else if (state_q == B_RUN) begin
			if (mstep_q != 3'(MUL_STEPS + 1)) mstep_q <= mstep_q + 3'd1;
			if (mstep_q < 3'(MUL_STEPS)) begin
				prod_q  <= mul_a * mul_b;
				shift_q <= 7'((mstep_q[0] ? PL : 0) + (mstep_q[1] ? QTY_HALF : 0));
			end
			if (mstep_q != 3'd0 && mstep_q != 3'(MUL_STEPS + 1))
				acc_q <= acc_q + (PW'(prod_q) << shift_q);
			if (dcnt_q != CW'(DW)) begin
				rem_q  <= ge ? trial - {1'b0, last_q} : trial;
				quo_q  <= {quo_q[DW-2:0], ge};
				dcnt_q <= dcnt_q + 1'b1;
			end
		end
	end

	assign notional_term = ((acc_q >> 80) != '0) ? '1 : SUM_BITS'(acc_q >> 16);
	assign ret_term      = ((quo_q >> RET_BITS) != '0) ? RET_MAX : SUM_BITS'(quo_q);
	assign qty_add = {1'b0, qty_sum} + (SUM_BITS+1)'(qty_q);
	assign not_add = {1'b0, notional_sum} + {1'b0, notional_term};
	assign mid_add = {1'b0, mid_sum} + (SUM_BITS+1)'(mid_q);
	assign ret_add = {1'b0, ret_sum} + {1'b0, ret_term};
	assign sp_add  = {{2{spread_sum[SUM_BITS-1]}}, spread_sum}
	               + (SUM_BITS+2)'($signed(spread_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks        <= '0;
			errors       <= '0;
			count        <= '0;
			qty_sum      <= '0;
			notional_sum <= '0;
			spread_sum   <= '0;
			mid_sum      <= '0;
			ret_sum      <= '0;
			lat_max      <= '0;
			next_q       <= '0;
			known_q      <= 1'b0;
			m_valid_q    <= 1'b0;
		end else begin
			if (update) begin
				m_valid_q <= 1'b1;
				ticks     <= ticks + 1'b1;
				if (known_q && seq_q != next_q) errors <= errors + 1'b1;
				next_q  <= seq_q + 1'b1;
				known_q <= 1'b1;
				if (new_slot_q && count != COUNT_MAX) count <= count + 1'b1;
				qty_sum      <= qty_add[SUM_BITS] ? '1 : qty_add[SUM_BITS-1:0];
				notional_sum <= not_add[SUM_BITS] ? '1 : not_add[SUM_BITS-1:0];
				mid_sum      <= mid_add[SUM_BITS] ? '1 : mid_add[SUM_BITS-1:0];
				ret_sum      <= ret_add[SUM_BITS] ? '1 : ret_add[SUM_BITS-1:0];
				if (sp_add[SUM_BITS+1:SUM_BITS-1] == 3'b000
				    || sp_add[SUM_BITS+1:SUM_BITS-1] == 3'b111)
					spread_sum <= sp_add[SUM_BITS-1:0];
				else
					spread_sum <= sp_add[SUM_BITS+1] ? {1'b1, {(SUM_BITS-1){1'b0}}}
					                                 : {1'b0, {(SUM_BITS-1){1'b1}}};
				if (lat_q > lat_max) lat_max <= lat_q;
			end else if (m_ready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign m_valid = m_valid_q;

endmodule

>>> sv/tick_stream_statistics_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tick_stream_statistics_core
// Running sequence, volume, notional, spread, mid, return and latency stats.
// ----------------------------------------------------------------------------
// Usage. Ticks enter on the s_ channel, one per transaction, and every tick
// produces exactly one snapshot of all running totals on the m_ channel.
// The front takes a tick, registering it with the instrument's last price
// read from the slot store, then pushes a classified record into a two-entry
// queue; it takes no new tick until that push, which waits for queue room.
// The back pops a record, forms the notional product from four partial
// products and, when the slot held a nonzero price, runs a one-bit-per-cycle
// divider over PRICE_BITS + 32 quotient bits. It takes no new record until
// the current one has been accumulated; when a return term is formed, the
// divider sets the sustained rate.
// After reset the slot store is swept clear, one entry a cycle, until all
// INSTRUMENT_SLOTS entries are zero; s_tready stays low during the sweep.
// The totals themselves form the output register: while the receiver stalls
// the snapshot holds, the back parks its next result and the front keeps
// filling the queue until it is full.
// ----------------------------------------------------------------------------
module tick_stream_statistics_core import tss_pkg::*; #(
	parameter int INSTRUMENT_SLOTS = 1024,
	parameter int PRICE_BITS       = 48,
	localparam int IN_RAW  = 3 * SEQ_BITS + 3 * PRICE_BITS + QTY_BITS + INST_BITS,
	localparam int IN_W    = ((IN_RAW + 7) / 8) * 8,
	localparam int OUT_RAW = 7 * SUM_BITS + COUNT_BITS + LAT_BITS,
	localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// sequence_number, event_time, receive_time, price, quantity, bid, ask,
	// instrument, zero fill
	input  logic [IN_W-1:0]     s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	// ticks_processed, gap total, distinct slot count, quantity_total,
	// notional_total, spread_total, mid_total, abs_return_total, latency_max,
	// zero fill
	output logic [OUT_W-1:0]    m_tdata
);

	localparam int PB     = PRICE_BITS;
	localparam int O_PR   = 3 * SEQ_BITS;
	localparam int O_QT   = O_PR + PB;
	localparam int O_BD   = O_QT + QTY_BITS;
	localparam int O_AK   = O_BD + PB;
	localparam int O_IN   = O_AK + PB;
	localparam int RW     = SEQ_BITS + LAT_BITS + QTY_BITS + 5 * PB + 3;

	logic [SEQ_BITS-1:0]   f_seq, b_seq;
	logic [LAT_BITS-1:0]   f_lat, b_lat;
	logic [QTY_BITS-1:0]   f_qty, b_qty;
	logic [PB-1:0]         f_price, f_mid, f_diff, f_last;
	logic [PB-1:0]         b_price, b_mid, b_diff, b_last;
	logic [PB:0]           f_spread, b_spread;
	logic                  f_new, f_ret, b_new, b_ret;
	front_stat_t           fstat;
	logic                  q_full, q_pop, q_nempty;
	logic [RW-1:0]         q_in, q_out;

	logic [SUM_BITS-1:0]   ticks, errors, qsum, nsum, ssum, msum, rsum;
	logic [COUNT_BITS-1:0] count;
	logic [LAT_BITS-1:0]   lmax;

	tss_front #(.SLOTS(INSTRUMENT_SLOTS), .PB(PB)) u_front (
		.clk(clk), .arst_n(arst_n),
		.s_valid(s_tvalid), .s_ready(s_tready),
		.seq(s_tdata[SEQ_BITS-1:0]),
		.ev(s_tdata[2*SEQ_BITS-1:SEQ_BITS]),
		.rx(s_tdata[3*SEQ_BITS-1:2*SEQ_BITS]),
		.price(s_tdata[O_PR +: PB]),
		.qty(s_tdata[O_QT +: QTY_BITS]),
		.bid(s_tdata[O_BD +: PB]),
		.ask(s_tdata[O_AK +: PB]),
		.inst(s_tdata[O_IN +: INST_BITS]),
		.full(q_full),
		.r_seq(f_seq), .r_lat(f_lat), .r_qty(f_qty), .r_price(f_price),
		.r_mid(f_mid), .r_spread(f_spread), .r_new_slot(f_new),
		.r_has_ret(f_ret), .r_diff(f_diff), .r_last(f_last),
		.stat(fstat)
	);

	assign q_in = {f_seq, f_lat, f_qty, f_price, f_mid, f_spread, f_new, f_ret,
	               f_diff, f_last};
	assign {b_seq, b_lat, b_qty, b_price, b_mid, b_spread, b_new, b_ret,
	        b_diff, b_last} = q_out;

	tss_fifo #(.W(RW)) u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(fstat.push), .push_data(q_in), .full(q_full),
		.pop(q_pop), .pop_data(q_out), .not_empty(q_nempty)
	);

	tss_back #(.PB(PB)) u_back (
		.clk(clk), .arst_n(arst_n),
		.rec_valid(q_nempty), .pop(q_pop),
		.r_seq(b_seq), .r_lat(b_lat), .r_qty(b_qty), .r_price(b_price),
		.r_mid(b_mid), .r_spread(b_spread), .r_new_slot(b_new),
		.r_has_ret(b_ret), .r_diff(b_diff), .r_last(b_last),
		.m_valid(m_tvalid), .m_ready(m_tready),
		.ticks(ticks), .errors(errors), .count(count), .qty_sum(qsum),
		.notional_sum(nsum), .spread_sum(ssum), .mid_sum(msum),
		.ret_sum(rsum), .lat_max(lmax)
	);

	assign m_tdata = OUT_W'({lmax, rsum, msum, ssum, nsum, qsum, count, errors, ticks});

`ifndef SYNTHESIS
	// No tick is taken while the slot store is being swept.
	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		fstat.clearing |-> !s_tready)
		else $error("tick accepted during slot clearing");
	// The front never pushes into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		fstat.push |-> !q_full)
		else $error("record queue overflow");
	// The back pops only records that exist.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_nempty)
		else $error("record queue underflow");
	// Each snapshot that raises m_tvalid advances the tick count by exactly one.
	a_tick_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> ticks == $past(ticks) + 1'b1)
		else $error("tick count skipped");
`endif

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for tick_stream_statistics_core.
// ----------------------------------------------------------------------------
// Ticks are driven on the s_ channel, and a running-statistics predictor
// forms the snapshot that each accepted tick should produce. Every snapshot
// on the m_ channel is compared field by field with the oldest prediction.
// The named tests cover a directed set of corner ticks, long random feeds,
// and a long receiver stall that fills the block and stalls its input.
// ----------------------------------------------------------------------------
module tb_top import tss_pkg::*; ();

	localparam int IN_W    = 392;
	localparam int OUT_W   = 528;
	localparam int SLOTS   = 1024;
	localparam int PB      = 48;
	localparam int LIMIT   = 900000;
	localparam int DRAIN   = 200;

	typedef struct {
		logic [63:0]      seq;
		logic [63:0]      ev;
		logic [63:0]      rx;
		logic [PB-1:0]    price;
		logic [39:0]      qty;
		logic [PB-1:0]    bid;
		logic [PB-1:0]    ask;
		logic [9:0]       inst;
	} tick_t;

	typedef struct {
		logic [63:0] ticks;
		logic [63:0] gaps;
		logic [10:0] inst_count;
		logic [63:0] qty_total;
		logic [63:0] notional_total;
		logic [63:0] spread_total;
		logic [63:0] mid_total;
		logic [63:0] return_total;
		logic [62:0] latency_max;
	} snapshot_t;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;

	// Predictor state, a copy of the block's running totals.
	logic [63:0] p_ticks, p_gaps, p_next_seq;
	logic        p_seq_known;
	logic [63:0] p_qty, p_notional, p_spread, p_mid, p_return;
	logic [62:0] p_latency;
	logic [10:0] p_seen;
	logic [PB-1:0] p_last_price [SLOTS];
	logic          p_slot_valid [SLOTS];

	snapshot_t pending_snapshots[$];
	int        mismatches;
	int        cycles;
	int        rx_hold_cycles;
	bit        tx_idle_en;
	bit        rx_idle_en;
	logic [63:0]   feed_seq;
	logic [PB-1:0] feed_price [32];

	tick_stream_statistics_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [63:0] sat_add64(logic [63:0] a, logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? '1 : s[63:0];
	endfunction

	// Applies one tick to the predictor state and returns the snapshot after it.
	function automatic snapshot_t apply_tick(tick_t t);
		snapshot_t   s;
		logic [87:0] product;
		logic [71:0] notional_term;
		logic signed [65:0] spread_next;
		logic [48:0] mid_term;
		logic signed [64:0] lat;
		logic [PB-1:0] last, diff;
		logic [79:0] ratio;

		if (p_seq_known && t.seq != p_next_seq)
			p_gaps++;
		p_next_seq  = t.seq + 64'd1;
		p_seq_known = 1'b1;
		p_ticks++;

		p_qty = sat_add64(p_qty, {24'd0, t.qty});
		product = t.price * t.qty;
		notional_term = product[87:16];
		p_notional = sat_add64(p_notional, (|notional_term[71:64]) ? '1 : notional_term[63:0]);

		// Spread is exact; only the running sum clamps, in both directions.
		spread_next = $signed({{2{p_spread[63]}}, p_spread})
			+ $signed({18'd0, t.ask}) - $signed({18'd0, t.bid});
		if (spread_next > $signed(66'h0_7FFF_FFFF_FFFF_FFFF))
			p_spread = 64'h7FFF_FFFF_FFFF_FFFF;
		else if (spread_next < -$signed(66'h0_8000_0000_0000_0000))
			p_spread = 64'h8000_0000_0000_0000;
		else
			p_spread = spread_next[63:0];

		mid_term = ({1'b0, t.ask} + {1'b0, t.bid}) >> 1;
		p_mid = sat_add64(p_mid, {15'd0, mid_term});

		lat = $signed({t.rx[63], t.rx}) - $signed({t.ev[63], t.ev});
		if (lat > 0) begin
			if (lat[64:63] != 2'b00)
				lat = {2'b00, {63{1'b1}}};
			if (lat[62:0] > p_latency)
				p_latency = lat[62:0];
		end

		if (p_slot_valid[t.inst]) begin
			last = p_last_price[t.inst];
			if (last != 0) begin
				diff  = (t.price >= last) ? t.price - last : last - t.price;
				ratio = {diff, 32'd0} / last;
				p_return = sat_add64(p_return, (ratio > 80'hFFFF_FFFF_FFFF) ?
					64'hFFFF_FFFF_FFFF : ratio[63:0]);
			end
		end else begin
			p_slot_valid[t.inst] = 1'b1;
			if (p_seen != COUNT_MAX)
				p_seen++;
		end
		p_last_price[t.inst] = t.price;

		s.ticks          = p_ticks;
		s.gaps           = p_gaps;
		s.inst_count     = p_seen;
		s.qty_total      = p_qty;
		s.notional_total = p_notional;
		s.spread_total   = p_spread;
		s.mid_total      = p_mid;
		s.return_total   = p_return;
		s.latency_max    = p_latency;
		return s;
	endfunction

	task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h expected %h at cycle %0d", field, got, want, cycles);
		mismatches++;
	endtask

	// Drives one tick and waits for its transaction; the prediction is queued
	// at the accepting edge. The valid stays high afterwards unless an idle gap
	// is chosen at the start of the next send.
	task automatic send_tick(tick_t t);
		@(negedge clk);
		if (tx_idle_en && $urandom_range(99) < 22) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(3, 1)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = {6'd0, t.inst, t.ask, t.bid, t.qty, t.price, t.rx, t.ev, t.seq};
		forever begin
			@(posedge clk);
			if (s_tready)
				break;
		end
		pending_snapshots.push_back(apply_tick(t));
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic int unsigned ku();
		return $urandom();
	endfunction

	function automatic tick_t noise_tick();
		tick_t t;
		t.seq   = ($urandom_range(3) == 0) ? feed_seq : rand64();
		t.ev    = rand64();
		t.rx    = rand64();
		t.price = PB'(rand64());
		t.qty   = 40'(rand64());
		t.bid   = PB'(rand64());
		t.ask   = PB'(rand64());
		t.inst  = 10'($urandom());
		return t;
	endfunction

	// A well-formed feed tick: next sequence number (now and then a gap),
	// a small non-negative latency and a price that mostly walks near its last value.
	function automatic tick_t feed_tick();
		tick_t t;
		int    k;
		k = $urandom_range(31);
		t.seq = ($urandom_range(19) == 0) ? feed_seq + $urandom_range(5, 2) : feed_seq;
		t.ev  = {1'b0, 31'($urandom()), $urandom()};
		t.rx  = t.ev + $urandom_range(100000);
		case ($urandom_range(9))
			0: feed_price[k] = {$urandom_range(1023), 16'(ku())};
			1: feed_price[k] = '0;
			2: feed_price[k] = PB'(rand64());
			default: feed_price[k] = feed_price[k] + $urandom_range(4096) - 2048;
		endcase
		t.price = feed_price[k];
		t.qty   = {24'($urandom_range(4095)), 16'(ku())};
		t.bid   = t.price - $urandom_range(512);
		t.ask   = t.price + $urandom_range(512);
		t.inst  = ($urandom_range(7) == 0) ? 10'($urandom()) : 10'(k);
		return t;
	endfunction

	task automatic send_random(int n, bit allow_idle);
		tick_t t;
		for (int i = 0; i < n; i++) begin
			tx_idle_en = allow_idle;
			rx_idle_en = allow_idle;
			t = ($urandom_range(99) < 70) ? feed_tick() : noise_tick();
			feed_seq = t.seq + 64'd1;
			send_tick(t);
		end
	endtask

	function automatic tick_t make_tick(logic [63:0] seq, logic [63:0] ev, logic [63:0] rx,
		logic [PB-1:0] price, logic [39:0] qty, logic [PB-1:0] bid, logic [PB-1:0] ask,
		logic [9:0] inst);
		tick_t t;
		t.seq = seq; t.ev = ev; t.rx = rx; t.price = price;
		t.qty = qty; t.bid = bid; t.ask = ask; t.inst = inst;
		return t;
	endfunction

	// Corner ticks: first tick, returns, a gap, a zero last price, sequence
	// wrap, saturating notional, inverted book, latency extremes, return clamp.
	task automatic test_directed();
		send_tick(make_tick(64'd0, 64'd100, 64'd250, 48'd100 << 16, 40'd1 << 16,
			48'd99 << 16, 48'd101 << 16, 10'd0));
		send_tick(make_tick(64'd1, 64'd300, 64'd310, 48'd110 << 16, 40'd3 << 16,
			48'd109 << 16, 48'd111 << 16, 10'd0));
		send_tick(make_tick(64'd5, 64'd400, 64'd390, 48'd0, 40'd0, 48'd0, 48'd0, 10'd0));
		send_tick(make_tick(64'd6, 64'd500, 64'd500, 48'd50 << 16, 40'd2, 48'd7, 48'd9,
			10'd0));
		send_tick(make_tick('1, 64'd0, 64'd1, 48'd60 << 16, 40'd2, 48'd1, 48'd2, 10'd0));
		send_tick(make_tick(64'd0, 64'd0, 64'd1, '1, '1, '1, '1, 10'd5));
		send_tick(make_tick(64'd1, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
			'1, '1, '1, '0, 10'd6));
		send_tick(make_tick(64'd2, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
			48'd1, '1, '0, '1, 10'd1023));
		send_tick(make_tick(64'd3, 64'd0, 64'd0, '1, 40'd1, 48'd3, 48'd5, 10'd1023));
		send_tick(make_tick(64'd3, 64'd0, 64'd0, 48'd1, 40'd1, 48'd3, 48'd5, 10'd1023));
		send_tick(make_tick(64'd4, 64'd0, 64'd0, 48'd2, 40'd1, 48'd2, 48'd1, 10'd512));
		send_tick(make_tick(64'd5, 64'd0, 64'd0, 48'd2, 40'd1, 48'd2, 48'd1, 10'd512));
		send_tick(make_tick(64'd6, 64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF,
			48'hAAAA_AAAA_AAAA, 40'h55_5555_5555, 48'h5555_5555_5555,
			48'hAAAA_AAAA_AAAA, 10'h155));
		send_tick(make_tick(64'd7, 64'd0, 64'd0, 48'h5555_5555_5555, 40'hAA_AAAA_AAAA,
			48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 10'h2AA));
		feed_seq = 8;
	endtask

	// The receiver stalls for a long stretch while ticks keep coming, so the
	// queue fills and the input handshake must stall too.
	task automatic test_backpressure();
		tx_idle_en = 1'b0;
		@(negedge clk);
		rx_hold_cycles = 1500;
		send_random(12, 1'b0);
	endtask

	task automatic test_random_feed();
		send_random(250, 1'b1);
		send_random(120, 1'b0);
		send_random(250, 1'b1);
	endtask

	// Receiver: random ready at the falling edge, or a counted hold-off.
	always @(negedge clk) begin
		if (rx_hold_cycles > 0) begin
			m_tready = 1'b0;
			rx_hold_cycles--;
		end else begin
			m_tready = !(rx_idle_en && $urandom_range(99) < 22);
		end
	end

	always @(posedge clk) begin
		snapshot_t w;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_snapshots.size() == 0) begin
				report_mismatch("unexpected snapshot", m_tdata[63:0], 64'd0);
			end else begin
				w = pending_snapshots.pop_front();
				if (m_tdata[63:0] != w.ticks)
					report_mismatch("ticks_processed", m_tdata[63:0], w.ticks);
				if (m_tdata[127:64] != w.gaps)
					report_mismatch("gap_total", m_tdata[127:64], w.gaps);
				if (m_tdata[138:128] != w.inst_count)
					report_mismatch("slot_count", 64'(m_tdata[138:128]),
						64'(w.inst_count));
				if (m_tdata[202:139] != w.qty_total)
					report_mismatch("quantity_total", m_tdata[202:139], w.qty_total);
				if (m_tdata[266:203] != w.notional_total)
					report_mismatch("notional_total", m_tdata[266:203], w.notional_total);
				if (m_tdata[330:267] != w.spread_total)
					report_mismatch("spread_total", m_tdata[330:267], w.spread_total);
				if (m_tdata[394:331] != w.mid_total)
					report_mismatch("mid_total", m_tdata[394:331], w.mid_total);
				if (m_tdata[458:395] != w.return_total)
					report_mismatch("abs_return_total", m_tdata[458:395], w.return_total);
				if (m_tdata[521:459] != w.latency_max)
					report_mismatch("latency_max", 64'(m_tdata[521:459]),
						64'(w.latency_max));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		mismatches = 0;
		cycles = 0;
		rx_hold_cycles = 0;
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		feed_seq = '0;
		p_ticks = '0; p_gaps = '0; p_next_seq = '0; p_seq_known = 1'b0;
		p_qty = '0; p_notional = '0; p_spread = '0; p_mid = '0; p_return = '0;
		p_latency = '0; p_seen = '0;
		for (int i = 0; i < SLOTS; i++) begin
			p_slot_valid[i] = 1'b0;
			p_last_price[i] = '0;
		end
		for (int i = 0; i < 32; i++)
			feed_price[i] = {$urandom_range(1023), 16'd0};
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_backpressure();
		test_random_feed();

		@(negedge clk);
		s_tvalid = 1'b0;
		rx_idle_en = 1'b0;
		while (pending_snapshots.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (mismatches == 0 && pending_snapshots.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

>>> tick_stream_statistics_core.f
sv/tss_pkg.sv
sv/tss_fifo.sv
sv/tss_front.sv
sv/tss_back.sv
sv/tick_stream_statistics_core.sv
bench/tb_top.sv
